// ===== sv/utf16_to_utf8_encoder_defines.svh =====
// Assertion macros shared by the encoder modules.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/u16u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Bytes that one queue entry can expand into.
	localparam int MAX_BYTES = 6;

	// Code point limits for the one, two and three byte forms.
	localparam logic [20:0] CP_LIMIT_1B = 21'h00080;
	localparam logic [20:0] CP_LIMIT_2B = 21'h00800;
	localparam logic [20:0] CP_LIMIT_3B = 21'h10000;

	// Upper six bits of high and low surrogates.
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	// What the main part of an entry asks the back part to send.
	typedef enum logic [1:0] {
		MAIN_NONE,
		MAIN_CP,
		MAIN_INC
	} main_kind_t;

	// One classified input item: an optional lone held surrogate first,
	// then the main code point, an incomplete marker, or nothing.
	typedef struct packed {
		logic       pre_valid;
		logic [9:0] pre_bits;
		main_kind_t kind;
		logic [20:0] cp;
	} entry_t;

	// Encoded bytes of one code point, first byte at index 0.
	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} enc_t;

	function automatic enc_t encode_cp(input logic [20:0] cp);
		enc_t r;
		r.b = '0;
		if (cp < CP_LIMIT_1B) begin
			r.b[0] = {1'b0, cp[6:0]};
			r.len  = 3'd1;
		end else if (cp < CP_LIMIT_2B) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.len  = 3'd2;
		end else if (cp < CP_LIMIT_3B) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.len  = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.len  = 3'd4;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/u16u8_unit_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel carrying UTF-16 code units into the encoder.
interface u16u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        final_unit;

	modport source (output valid, output code_unit, output final_unit, input ready);
	modport sink (input valid, input code_unit, input final_unit, output ready);
endinterface

`default_nettype wire

// ===== sv/u16u8_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel carrying UTF-8 result bytes out of the encoder.
interface u16u8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       incomplete;

	modport source (output valid, output out_byte, output run_end, output incomplete,
		input ready);
	modport sink (input valid, input out_byte, input run_end, input incomplete,
		output ready);
endinterface

`default_nettype wire

// ===== sv/u16u8_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_defines.svh"

module u16u8_queue #(
	parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u16u8_pkg::entry_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output u16u8_pkg::entry_t      pop_data,
	output logic                   empty
);
	import u16u8_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`U16U8_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL_CNT, "queue count overflow")

endmodule

`default_nettype wire

// ===== sv/u16u8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_defines.svh"

module u16u8_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	u16u8_unit_if.sink         units,
	output logic               push,
	output u16u8_pkg::entry_t  push_data,
	input  wire logic          full
);
	import u16u8_pkg::*;

	logic [9:0] held_bits_q;
	logic       held_v_q;
	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       want_push;
	entry_t     ent;

	assign units.ready = !full;
	assign accept      = units.valid && units.ready;
	assign is_high     = (units.code_unit[15:10] == HIGH_SURR_TAG);
	assign is_low      = (units.code_unit[15:10] == LOW_SURR_TAG);

	// Classify the unit against the held surrogate.
	always_comb begin
		ent           = '0;
		ent.kind      = MAIN_NONE;
		want_push     = 1'b1;
		if (held_v_q && is_low) begin
			ent.kind = MAIN_CP;
			ent.cp   = {1'b0, held_bits_q, units.code_unit[9:0]} + CP_LIMIT_3B;
		end else begin
			ent.pre_valid = held_v_q;
			ent.pre_bits  = held_bits_q;
			if (is_high) begin
				if (units.final_unit) begin
					ent.kind = MAIN_INC;
				end else begin
					ent.kind  = MAIN_NONE;
					want_push = held_v_q;
				end
			end else begin
				ent.kind = MAIN_CP;
				ent.cp   = {5'b0, units.code_unit};
			end
		end
	end

	assign push      = accept && want_push;
	assign push_data = ent;

	// Held high surrogate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q    <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			held_v_q <= is_high && !units.final_unit;
			if (is_high && !units.final_unit) begin
				held_bits_q <= units.code_unit[9:0];
			end
		end
	end

	`U16U8_ASSERT_NEXT(a_final_clears, clk, arst_n, accept && units.final_unit, !held_v_q, "surrogate held after final unit")
	`U16U8_ASSERT_NEXT(a_none_holds, clk, arst_n, push && (ent.kind == MAIN_NONE), held_v_q, "prefix-only entry without a new held surrogate")

endmodule

`default_nettype wire

// ===== sv/u16u8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_encoder_defines.svh"

module u16u8_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire u16u8_pkg::entry_t pop_data,
	input  wire logic              empty,
	output logic                   pop,
	u16u8_byte_if.source           octets
);
	import u16u8_pkg::*;

	logic [MAX_BYTES-1:0][7:0] bytes_q;
	logic [2:0]                cnt_q;
	logic [2:0]                idx_q;
	logic                      inc_q;
	logic                      busy_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      out_end_q;
	logic                      out_inc_q;

	logic                      emit;
	logic                      last_emit;
	logic                      load;
	enc_t                      pre_enc;
	enc_t                      main_enc;
	logic [MAX_BYTES-1:0][7:0] load_bytes;
	logic [2:0]                load_cnt;

	// Expand the head entry into its byte list.
	always_comb begin
		pre_enc  = encode_cp({5'b0, HIGH_SURR_TAG, pop_data.pre_bits});
		main_enc = encode_cp(pop_data.cp);
		case (pop_data.kind)
			MAIN_CP: begin
			end
			MAIN_INC: begin
				main_enc.b   = '0;
				main_enc.len = 3'd1;
			end
			default: begin
				main_enc.b   = '0;
				main_enc.len = 3'd0;
			end
		endcase
		if (pop_data.pre_valid) begin
			load_bytes = {main_enc.b[2], main_enc.b[1], main_enc.b[0],
				pre_enc.b[2], pre_enc.b[1], pre_enc.b[0]};
			load_cnt   = main_enc.len + 3'd3;
		end else begin
			load_bytes = {16'h0000, main_enc.b};
			load_cnt   = main_enc.len;
		end
	end

	assign emit      = busy_q && (!out_valid_q || octets.ready);
	assign last_emit = emit && (idx_q == cnt_q - 3'd1);
	assign load      = !empty && (!busy_q || last_emit);
	assign pop       = load;

	// Byte serializer working register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= load_cnt;
		end else if (last_emit) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// Working payload.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_bytes;
			inc_q   <= (pop_data.kind == MAIN_INC);
		end
	end

	// Output register, parting the serializer from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (octets.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= bytes_q[idx_q];
			out_end_q  <= last_emit;
			out_inc_q  <= inc_q && last_emit;
		end
	end

	assign octets.valid      = out_valid_q;
	assign octets.out_byte   = out_byte_q;
	assign octets.run_end    = out_end_q;
	assign octets.incomplete = out_inc_q;

	`U16U8_ASSERT_NOW(a_inc_is_end, clk, arst_n, out_valid_q && out_inc_q, out_end_q && (out_byte_q == 8'h00), "incomplete result not last or not empty")
	`U16U8_ASSERT_NOW(a_busy_cnt, clk, arst_n, busy_q, (cnt_q != 3'd0) && (idx_q < cnt_q), "serializer index out of range")

endmodule

`default_nettype wire

// ===== sv/utf16_to_utf8_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-16 to UTF-8 encoder. One code unit enters per transfer on units and
// the UTF-8 bytes leave one per transfer on octets, most significant byte
// first, with run_end marking the last byte caused by each unit. A high
// surrogate is held until the next unit: a following low surrogate makes a
// four byte sequence, otherwise the held surrogate goes out alone as three
// bytes. A high surrogate on the final unit gives one result with incomplete
// set and a zero byte. The front part classifies a unit in the cycle it is
// accepted and can take a new unit every cycle while its queue has room; the
// back part's byte serializer sends one byte per cycle while the consumer is
// ready, so a unit in the basic plane gives one to three bytes, a surrogate
// pair four bytes over two units, and a lone held surrogate adds three.
// Sustained throughput is set by that serializer.
module utf16_to_utf8_encoder #(
	parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	u16u8_unit_if.sink    units,
	u16u8_byte_if.source  octets
);
	import u16u8_pkg::*;

	logic   push;
	logic   full;
	logic   pop;
	logic   empty;
	entry_t push_data;
	entry_t pop_data;

	// Classification and surrogate holding.
	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.units     (units),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Decoupling queue.
	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// Byte serializer.
	u16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.octets   (octets)
	);

endmodule

`default_nettype wire

// ===== tb/sv/utf16_to_utf8_encoder_tb.sv =====
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_tb;
	import u16u8_pkg::*;

	localparam int UNIT_COUNT = 460;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	// One UTF-8 result as it should leave the encoder.
	typedef struct {
		logic [7:0] value;
		logic       run_end;
		logic       incomplete;
	} utf8_result_t;

	// Predicts the UTF-8 bytes for each accepted code unit and checks every
	// byte transfer against the oldest prediction.
	class utf8_byte_scoreboard;
		utf8_result_t pending_bytes[$];
		utf8_result_t step_out[$];
		logic         held_valid;
		logic [9:0]   held_bits;
		int unsigned  errors;

		function new();
			held_valid = 1'b0;
			held_bits = '0;
			errors = 0;
		endfunction

		function void push_result(logic [7:0] value, logic incomplete);
			utf8_result_t r;
			r.value = value;
			r.run_end = 1'b0;
			r.incomplete = incomplete;
			step_out.push_back(r);
		endfunction

		// Expands a code point into its one to four byte UTF-8 form.
		function void push_code_point(logic [20:0] cp);
			if (cp < CP_LIMIT_1B) begin
				push_result({1'b0, cp[6:0]}, 1'b0);
			end else if (cp < CP_LIMIT_2B) begin
				push_result({3'b110, cp[10:6]}, 1'b0);
				push_result({2'b10, cp[5:0]}, 1'b0);
			end else if (cp < CP_LIMIT_3B) begin
				push_result({4'b1110, cp[15:12]}, 1'b0);
				push_result({2'b10, cp[11:6]}, 1'b0);
				push_result({2'b10, cp[5:0]}, 1'b0);
			end else begin
				push_result({5'b11110, cp[20:18]}, 1'b0);
				push_result({2'b10, cp[17:12]}, 1'b0);
				push_result({2'b10, cp[11:6]}, 1'b0);
				push_result({2'b10, cp[5:0]}, 1'b0);
			end
		endfunction

		function void note_unit(logic [15:0] cu, logic last);
			logic         is_high;
			logic         is_low;
			logic         paired;
			utf8_result_t r;
			is_high = (cu[15:10] == HIGH_SURR_TAG);
			is_low = (cu[15:10] == LOW_SURR_TAG);
			paired = 1'b0;
			step_out.delete();

			// A held high surrogate either pairs with this unit or goes out alone.
			if (held_valid) begin
				held_valid = 1'b0;
				if (is_low) begin
					push_code_point(21'h10000 + {1'b0, held_bits, cu[9:0]});
					paired = 1'b1;
				end else begin
					push_code_point({5'd0, HIGH_SURR_TAG, held_bits});
				end
			end

			// The unit itself, unless it completed a pair.
			if (!paired) begin
				if (is_high) begin
					if (last) begin
						push_result(8'h00, 1'b1);
					end else begin
						held_bits = cu[9:0];
						held_valid = 1'b1;
					end
				end else begin
					push_code_point({5'd0, cu});
				end
			end

			// The last byte caused by this unit closes its run.
			if (step_out.size() > 0) begin
				r = step_out.pop_back();
				r.run_end = 1'b1;
				step_out.push_back(r);
			end
			foreach (step_out[i])
				pending_bytes.push_back(step_out[i]);
		endfunction

		function void check_byte(logic [7:0] value, logic run_end, logic incomplete);
			utf8_result_t exp_r;
			if (pending_bytes.size() == 0) begin
				$error("unexpected result: out_byte %02h run_end %0b incomplete %0b",
					value, run_end, incomplete);
				errors++;
				return;
			end
			exp_r = pending_bytes.pop_front();
			if (value !== exp_r.value) begin
				$error("out_byte: expected %02h, got %02h", exp_r.value, value);
				errors++;
			end
			if (run_end !== exp_r.run_end) begin
				$error("run_end: expected %0b, got %0b", exp_r.run_end, run_end);
				errors++;
			end
			if (incomplete !== exp_r.incomplete) begin
				$error("incomplete: expected %0b, got %0b", exp_r.incomplete, incomplete);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic no_idle = 1'b0;
	int   units_sent = 0;
	int   cycles = 0;

	utf8_byte_scoreboard sb = new();

	u16u8_unit_if units_ch();
	u16u8_byte_if octets_ch();

	utf16_to_utf8_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.units  (units_ch),
		.octets (octets_ch)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Both channels are sampled at the clock edge; an input transfer is noted
	// before any byte of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (units_ch.valid && units_ch.ready)
				sb.note_unit(units_ch.code_unit, units_ch.final_unit);
			if (octets_ch.valid && octets_ch.ready)
				sb.check_byte(octets_ch.out_byte, octets_ch.run_end, octets_ch.incomplete);
		end
	end

	// Byte sink: a random stall before each transfer, none in burst phases.
	initial begin
		int stall;
		octets_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				octets_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			octets_ch.ready <= 1'b1;
			do @(posedge clk); while (!octets_ch.valid);
		end
	end

	// Offers one code unit after a random gap and waits for its transfer.
	task automatic send_unit(input logic [15:0] cu, input logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			units_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		units_ch.valid <= 1'b1;
		units_ch.code_unit <= cu;
		units_ch.final_unit <= last;
		do @(posedge clk); while (!units_ch.ready);
		units_sent++;
	endtask

	// Holds the sender off until every predicted byte has come out.
	task automatic wait_for_drain();
		units_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_bytes.size() != 0);
	endtask

	// Range edges of each byte length, the smallest and largest pairs, a lone
	// low surrogate, and a held surrogate meeting a plain unit, another high
	// surrogate, a final plain unit and a final high surrogate.
	task automatic run_directed();
		logic [15:0] dir_cu[25] = '{
			16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD7FF,
			16'hE000, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC00, 16'hDA55,
			16'h0041, 16'hD801, 16'hDBFE, 16'hDC01, 16'hD9AA, 16'h00E9, 16'hDBFF,
			16'hD800, 16'hDAAA, 16'h5555, 16'hAAAA};
		logic dir_last[25] = '{
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
			1'b0, 1'b1, 1'b1, 1'b0};
		foreach (dir_cu[i])
			send_unit(dir_cu[i], dir_last[i]);
	endtask

	// One random piece of text: mostly valid units and pairs, with some lone
	// surrogates, truncated pairs and fully random units.
	task automatic send_random_piece();
		int   kind;
		logic last;
		kind = $urandom_range(0, 9);
		last = ($urandom_range(0, 7) == 0);
		case (kind)
			0: send_unit(16'($urandom_range(16'h0000, 16'h007F)), last);
			1: send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
			2: begin
				if ($urandom_range(0, 1))
					send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last);
				else
					send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
			end
			3, 4, 5: begin
				send_unit({HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
				send_unit({LOW_SURR_TAG, 10'($urandom)}, last);
			end
			6: send_unit({HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
			7: send_unit({LOW_SURR_TAG, 10'($urandom)}, last);
			8: send_unit(16'($urandom), 1'($urandom));
			default: send_unit({HIGH_SURR_TAG, 10'($urandom)}, 1'b1);
		endcase
	endtask

	// Random text in phases of about fifty units, some of them without idling,
	// with one full drain about halfway.
	task automatic run_random();
		int next_phase;
		bit drained;
		next_phase = units_sent;
		drained = 1'b0;
		while (units_sent < UNIT_COUNT) begin
			if (units_sent >= next_phase) begin
				no_idle = ($urandom_range(0, 3) == 0);
				next_phase += 50;
			end
			if (!drained && units_sent >= UNIT_COUNT / 2) begin
				wait_for_drain();
				drained = 1'b1;
			end
			send_random_piece();
		end
		no_idle = 1'b0;
	endtask

	// Reset, stimulus, and the final verdict.
	initial begin
		arst_n <= 1'b0;
		units_ch.valid <= 1'b0;
		units_ch.code_unit <= '0;
		units_ch.final_unit <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random();
		units_ch.valid <= 1'b0;

		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending_bytes.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/u16u8_pkg.sv
sv/u16u8_unit_if.sv
sv/u16u8_byte_if.sv
sv/u16u8_queue.sv
sv/u16u8_front.sv
sv/u16u8_back.sv
sv/utf16_to_utf8_encoder.sv
tb/sv/utf16_to_utf8_encoder_tb.sv
